// ===== src/bmp_pkg.sv =====
package bmp_pkg;

    // Default size limit for image width and height magnitude.
    localparam int MAX_DIM_DEF = 2048;

    // Widths fixed by the stream format.
    localparam int BYTE_W   = 8;
    localparam int ORIGIN_W = 13;
    localparam int PIX_W    = 14;
    localparam int COLOR_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 6;
    localparam int WORD_W   = 32;

    // Configuration register indexes.
    localparam logic [0:0] REG_X_ORIGIN = 1'd0;
    localparam logic [0:0] REG_Y_ORIGIN = 1'd1;

    // Header layout: offsets are those of the last byte of each field.
    localparam logic [OFF_W-1:0] OFF_MAGIC_END  = 6'h01;
    localparam logic [OFF_W-1:0] OFF_WIDTH_END  = 6'h15;
    localparam logic [OFF_W-1:0] OFF_HEIGHT_END = 6'h19;
    localparam logic [OFF_W-1:0] OFF_DEPTH_END  = 6'h1d;
    localparam logic [OFF_W-1:0] OFF_HEADER_END = 6'h35;

    localparam logic [BYTE_W-1:0] MAGIC_B = 8'h42;
    localparam logic [BYTE_W-1:0] MAGIC_M = 8'h4d;

    localparam logic [15:0] DEPTH_24 = 16'd24;
    localparam logic [15:0] DEPTH_32 = 16'd32;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_PIXELS = 2'd2,
        PH_PAD    = 2'd3
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PIXEL     = 2'd0,
        ST_NOT_BMP   = 2'd1,
        ST_BAD_DEPTH = 2'd2,
        ST_OVERSIZE  = 2'd3
    } status_t;

endpackage

// ===== src/bmp_stream_pixel_decoder_top.sv =====
// Streaming BMP decoder for 24- and 32-bit images. File bytes arrive one per word on the
// slave side, with tuser set on the byte at file offset zero, which restarts the parse at
// any time. The header is checked for the "BM" magic, a depth of 24 or 32 and a width and
// height magnitude of at most MAX_DIM; a failure is reported once as a word with a nonzero
// status and tlast set, and further bytes are dropped until the next first byte. An image
// with zero width or height produces nothing. Each pixel leaves as one word with its ARGB
// color (alpha zero for 24-bit data) and its screen position, column plus x origin and
// height minus (row plus y origin), both wrapped to 14 bits; tlast marks the final pixel.
// Row padding of 24-bit images is skipped. The decoder takes one byte every cycle unless
// stalled; a result appears in the cycle after the byte that completes it, in a single
// output register; only its downstream stall holds off input. There is no clearing pass.
module bmp_stream_pixel_decoder_top #(
    parameter int MAX_DIM = bmp_pkg::MAX_DIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration writes.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_addr,
    input  logic [bmp_pkg::ORIGIN_W-1:0]  cfg_data,
    // Input bytes.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] data_byte
    input  logic                          s_tuser,  // [0] first
    // Results.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,  // [13:0] pixel_x, [27:14] pixel_y,
                                                    // [59:28] color, [63:60] zero
    output logic [bmp_pkg::STATUS_W-1:0]  m_tuser,  // [1:0] status
    output logic                          m_tlast   // last
);
    import bmp_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam logic [WORD_W-1:0] MAX_WORD = WORD_W'(MAX_DIM);

    // Configuration.
    logic signed [ORIGIN_W-1:0] x_origin_reg, y_origin_reg;

    // Parser state.
    phase_t              phase_reg, phase_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [23:0]         hdr_reg, hdr_next;
    logic [DIM_W-1:0]    width_reg, width_next;
    logic                width_over_reg, width_over_next;
    logic                width_zero_reg, width_zero_next;
    logic [DIM_W-1:0]    hmag_reg, hmag_next;
    logic [PIX_W-1:0]    hlow_reg, hlow_next;
    logic                height_over_reg, height_over_next;
    logic                height_zero_reg, height_zero_next;
    logic                alpha_reg, alpha_next;
    logic [DIM_W-1:0]    col_reg, col_next;
    logic [DIM_W-1:0]    row_reg, row_next;
    logic [1:0]          bip_reg, bip_next;
    logic [1:0]          pad_reg, pad_next;
    logic [BYTE_W-1:0]   c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;

    // Result register.
    logic                m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]    px_reg, px_next, py_reg, py_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    status_t             status_reg, status_next;
    logic                last_reg, last_next;

    logic                accept, emit;
    phase_t              cur_phase;
    logic [OFF_W-1:0]    cur_off;
    logic [23:0]         cur_hdr;
    logic [BYTE_W-1:0]   b;
    logic [WORD_W-1:0]   word, hmag_full;
    logic [15:0]         depth;
    logic [DIM_W-1:0]    col_inc, row_inc;
    logic [PIX_W-1:0]    px, py;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign b         = s_tdata;

    // A first byte restarts the header parse from offset zero.
    assign cur_phase = s_tuser ? PH_HEADER : phase_reg;
    assign cur_off   = s_tuser ? '0 : off_reg;
    assign cur_hdr   = s_tuser ? '0 : hdr_reg;

    assign word      = {b, cur_hdr};
    assign depth     = {b, cur_hdr[23:16]};
    assign hmag_full = word[WORD_W-1] ? (WORD_W'(0) - word) : word;
    assign col_inc   = col_reg + DIM_W'(1);
    assign row_inc   = row_reg + DIM_W'(1);
    assign px = PIX_W'(col_reg) + PIX_W'(x_origin_reg);
    assign py = hlow_reg - (PIX_W'(row_reg) + PIX_W'(y_origin_reg));

    always_comb begin
        phase_next       = phase_reg;
        off_next         = off_reg;
        hdr_next         = hdr_reg;
        width_next       = width_reg;
        width_over_next  = width_over_reg;
        width_zero_next  = width_zero_reg;
        hmag_next        = hmag_reg;
        hlow_next        = hlow_reg;
        height_over_next = height_over_reg;
        height_zero_next = height_zero_reg;
        alpha_next       = alpha_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        bip_next         = bip_reg;
        pad_next         = pad_reg;
        c0_next          = c0_reg;
        c1_next          = c1_reg;
        c2_next          = c2_reg;
        emit             = 1'b0;
        status_next      = status_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        color_next       = color_reg;
        last_next        = last_reg;

        if (accept) begin
            if (s_tuser) begin
                phase_next = PH_HEADER;
                off_next   = '0;
                hdr_next   = '0;
                col_next   = '0;
                row_next   = '0;
                bip_next   = '0;
                pad_next   = '0;
            end
            unique case (cur_phase)
                PH_HEADER: begin
                    hdr_next = word[WORD_W-1:8];
                    off_next = cur_off + OFF_W'(1);
                    unique case (cur_off)
                        OFF_MAGIC_END: begin
                            if (cur_hdr[23:16] != MAGIC_B || b != MAGIC_M) begin
                                emit        = 1'b1;
                                status_next = ST_NOT_BMP;
                            end
                        end
                        OFF_WIDTH_END: begin
                            width_next      = word[DIM_W-1:0];
                            width_over_next = word > MAX_WORD;
                            width_zero_next = word == '0;
                        end
                        OFF_HEIGHT_END: begin
                            hmag_next        = hmag_full[DIM_W-1:0];
                            hlow_next        = word[PIX_W-1:0];
                            height_over_next = hmag_full > MAX_WORD;
                            height_zero_next = word == '0;
                        end
                        OFF_DEPTH_END: begin
                            alpha_next = depth == DEPTH_32;
                            if (depth != DEPTH_24 && depth != DEPTH_32) begin
                                emit        = 1'b1;
                                status_next = ST_BAD_DEPTH;
                            end else if (width_over_reg || height_over_reg) begin
                                emit        = 1'b1;
                                status_next = ST_OVERSIZE;
                            end else if (width_zero_reg || height_zero_reg) begin
                                phase_next = PH_IDLE;
                            end
                        end
                        OFF_HEADER_END: begin
                            phase_next = PH_PIXELS;
                            col_next   = '0;
                            row_next   = '0;
                            bip_next   = '0;
                        end
                        default: begin
                        end
                    endcase
                    if (emit) begin
                        phase_next = PH_IDLE;
                        px_next    = '0;
                        py_next    = '0;
                        color_next = '0;
                        last_next  = 1'b1;
                    end
                end
                PH_PAD: begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1) begin
                        phase_next = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    case (bip_reg)
                        2'd0:    c0_next = b;
                        2'd1:    c1_next = b;
                        2'd2:    c2_next = b;
                        default: begin
                        end
                    endcase
                    if (bip_reg < {1'b1, alpha_reg}) begin
                        bip_next = bip_reg + 2'd1;
                    end else begin
                        // Last byte of the pixel: alpha for 32-bit, red for 24-bit.
                        emit        = 1'b1;
                        status_next = ST_PIXEL;
                        px_next     = px;
                        py_next     = py;
                        color_next  = alpha_reg ? {b, c2_reg, c1_reg, c0_reg}
                                                : {8'h00, b, c1_reg, c0_reg};
                        last_next   = 1'b0;
                        bip_next    = '0;
                        col_next    = col_inc;
                        if (col_inc == width_reg) begin
                            col_next = '0;
                            if (row_inc == hmag_reg) begin
                                last_next  = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                row_next = row_inc;
                                if (!alpha_reg && width_reg[1:0] != 2'd0) begin
                                    pad_next   = width_reg[1:0];
                                    phase_next = PH_PAD;
                                end
                            end
                        end
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                end
            endcase
        end

        m_valid_next = m_valid_reg;
        if (s_tready) begin
            m_valid_next = accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            phase_reg    <= PH_IDLE;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    REG_X_ORIGIN: x_origin_reg <= cfg_data;
                    REG_Y_ORIGIN: y_origin_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg         <= off_next;
        hdr_reg         <= hdr_next;
        width_reg       <= width_next;
        width_over_reg  <= width_over_next;
        width_zero_reg  <= width_zero_next;
        hmag_reg        <= hmag_next;
        hlow_reg        <= hlow_next;
        height_over_reg <= height_over_next;
        height_zero_reg <= height_zero_next;
        alpha_reg       <= alpha_next;
        col_reg         <= col_next;
        row_reg         <= row_next;
        bip_reg         <= bip_next;
        pad_reg         <= pad_next;
        c0_reg          <= c0_next;
        c1_reg          <= c1_next;
        c2_reg          <= c2_next;
        status_reg      <= status_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        color_reg       <= color_next;
        last_reg        <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, color_reg, py_reg, px_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule
